@@ src/cpst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpst_pkg
// Shared types and constants of the channel peak sync tracker: item layouts,
// window records, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package cpst_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int POS_W       = 9;
    localparam int POWER_W     = 33;
    localparam int OFFSET_W    = 19;
    localparam int COEF_W      = 15;
    localparam int HALF_SQ_W   = 30;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 19;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_COEF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_POSITION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH    = 2'd3;

    localparam logic [COEF_W-1:0]   COEF_RESET   = 15'd0;
    localparam logic [POS_W-1:0]    TARGET_RESET = 9'd16;
    localparam logic [POS_W-1:0]    HYST_RESET   = 9'd1;
    localparam logic [OFFSET_W-1:0] FRAME_RESET  = 19'd76800;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
        logic                       last_antenna;
        logic                       last_position;
        logic                       clear_filter;
        logic [OFFSET_W-1:0]        current_offset;
    } t_in_item;

    typedef struct packed {
        logic [OFFSET_W-1:0] new_offset;
        logic [POS_W-1:0]    peak_position;
        logic [POS_W-1:0]    filtered_position;
        logic [POWER_W-1:0]  peak_power;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0]    peak_position;
        logic [POWER_W-1:0]  peak_power;
        logic                clear_filter;
        logic [OFFSET_W-1:0] current_offset;
    } t_win_rec;

    typedef struct packed {
        logic [COEF_W-1:0]   smoothing_coef;
        logic [POS_W-1:0]    target_position;
        logic [POS_W-1:0]    hysteresis;
        logic [OFFSET_W-1:0] frame_length;
    } t_cfg;

endpackage

@@ src/cpst_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpst_in_if
// Sample channel: valid/ready handshake carrying one channel-estimate sample.
// ----------------------------------------------------------------------------
interface cpst_in_if;
    logic               valid;
    logic               ready;
    cpst_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ src/cpst_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpst_out_if
// Result channel: valid/ready handshake carrying one window result.
// ----------------------------------------------------------------------------
interface cpst_out_if;
    logic                valid;
    logic                ready;
    cpst_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ src/cpst_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpst_front
// Sample front end: squares each sample, accumulates power per position,
// tracks the strongest position and hands a record on at every window end.
// ----------------------------------------------------------------------------
module cpst_front #(
    parameter int MAX_WINDOW = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cpst_in_if.sink             i_in,
    output logic                o_rec_valid,
    input  logic                i_rec_ready,
    output cpst_pkg::t_win_rec  o_rec
);

    localparam int CNT_W = $clog2(MAX_WINDOW);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_WINDOW - 1);

    function automatic logic [cpst_pkg::HALF_SQ_W-1:0] half_square(
        input logic [cpst_pkg::SAMPLE_W-1:0] v
    );
        logic [cpst_pkg::SAMPLE_W-1:0]   mag;
        logic [2*cpst_pkg::SAMPLE_W-1:0] sq;
        mag = v[cpst_pkg::SAMPLE_W-1] ? (~v + 16'd1) : v;
        sq  = mag * mag;
        return sq[cpst_pkg::HALF_SQ_W:1];
    endfunction

    // Stage 1: squared halves and item flags
    logic                               r_s1_valid;
    logic [cpst_pkg::HALF_SQ_W-1:0]     r_sq_re;
    logic [cpst_pkg::HALF_SQ_W-1:0]     r_sq_im;
    logic                               r_last_ant;
    logic                               r_last_pos;
    logic                               r_clear;
    logic [cpst_pkg::OFFSET_W-1:0]      r_offset;

    // Window state
    logic [cpst_pkg::POWER_W-1:0]       r_accum, n_accum;
    logic [cpst_pkg::POWER_W-1:0]       r_best, n_best;
    logic [CNT_W-1:0]                   r_best_pos, n_best_pos;
    logic [CNT_W-1:0]                   r_pos, n_pos;

    logic [cpst_pkg::POWER_W:0]         sum_wide;
    logic [cpst_pkg::POWER_W-1:0]       accum_sat;
    logic                               better;
    logic [cpst_pkg::POWER_W-1:0]       win_pow;
    logic [CNT_W-1:0]                   win_pos;
    logic                               is_end;
    logic                               s1_adv;
    logic                               in_fire;

    assign sum_wide  = {1'b0, r_accum} + (cpst_pkg::POWER_W + 1)'(r_sq_re)
                     + (cpst_pkg::POWER_W + 1)'(r_sq_im);
    assign accum_sat = sum_wide[cpst_pkg::POWER_W] ? '1 : sum_wide[cpst_pkg::POWER_W-1:0];
    assign better    = accum_sat > r_best;
    assign win_pow   = better ? accum_sat : r_best;
    assign win_pos   = better ? r_pos : r_best_pos;
    assign is_end    = r_last_ant & r_last_pos;

    // A window end may only leave stage 1 when the queue has room.
    assign s1_adv    = r_s1_valid & (~is_end | i_rec_ready);
    assign i_in.ready = ~r_s1_valid | s1_adv;
    assign in_fire   = i_in.valid & i_in.ready;

    assign o_rec_valid          = s1_adv & is_end;
    assign o_rec.peak_position  = cpst_pkg::POS_W'(win_pos);
    assign o_rec.peak_power     = win_pow;
    assign o_rec.clear_filter   = r_clear;
    assign o_rec.current_offset = r_offset;

    always_comb begin
        n_accum    = r_accum;
        n_best     = r_best;
        n_best_pos = r_best_pos;
        n_pos      = r_pos;
        if (s1_adv) begin
            if (!r_last_ant) begin
                n_accum = accum_sat;
            end else if (r_last_pos) begin
                n_accum    = '0;
                n_best     = '0;
                n_best_pos = '0;
                n_pos      = '0;
            end else begin
                n_accum    = '0;
                n_best     = win_pow;
                n_best_pos = win_pos;
                if (r_pos < LAST_CNT) begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_accum    <= '0;
            r_best     <= '0;
            r_best_pos <= '0;
            r_pos      <= '0;
        end else begin
            r_s1_valid <= in_fire | (r_s1_valid & ~s1_adv);
            r_accum    <= n_accum;
            r_best     <= n_best;
            r_best_pos <= n_best_pos;
            r_pos      <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sq_re    <= half_square(i_in.payload.sample_re);
            r_sq_im    <= half_square(i_in.payload.sample_im);
            r_last_ant <= i_in.payload.last_antenna;
            r_last_pos <= i_in.payload.last_position;
            r_clear    <= i_in.payload.clear_filter;
            r_offset   <= i_in.payload.current_offset;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_CNT && r_best_pos <= LAST_CNT)
        else $error("position counter beyond window");

    a_accum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_last_ant |=> r_accum == '0)
        else $error("accumulator not cleared after last antenna");

endmodule

@@ src/cpst_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpst_queue
// Short queue of window records between the sample front end and the
// window back end.
// ----------------------------------------------------------------------------
module cpst_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    output logic                o_push_ready,
    input  cpst_pkg::t_win_rec  i_push_rec,
    output logic                o_pop_valid,
    input  logic                i_pop_ready,
    output cpst_pkg::t_win_rec  o_pop_rec
);

    localparam int DEPTH = cpst_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cpst_pkg::t_win_rec r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = r_count != FULL_CNT;
    assign o_pop_valid  = r_count != '0;
    assign o_pop_rec    = r_mem[r_rd_ptr];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_rec;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue fill count beyond depth");

    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue fill count did not follow a transfer in");

endmodule

@@ src/cpst_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpst_back
// Window back end: smooths the peak position, compares it with the target
// and dead band, steps and wraps the receive offset, holds the result.
// ----------------------------------------------------------------------------
module cpst_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpst_pkg::t_cfg      i_cfg,
    input  logic                i_rec_valid,
    output logic                o_rec_ready,
    input  cpst_pkg::t_win_rec  i_rec,
    cpst_out_if.source          o_out
);

    localparam int OFF_S_W = cpst_pkg::OFFSET_W + 2;

    // Filter state, kept across windows
    logic [cpst_pkg::POS_W-1:0]     r_smooth;

    // Stage A: filtered position
    logic                           r_a_valid;
    logic [cpst_pkg::POS_W-1:0]     r_a_filt;
    logic [cpst_pkg::POS_W-1:0]     r_a_pos;
    logic [cpst_pkg::POWER_W-1:0]   r_a_pow;
    logic [cpst_pkg::OFFSET_W-1:0]  r_a_off;

    // Stage B: stepped offset
    logic                           r_b_valid;
    logic [cpst_pkg::POS_W-1:0]     r_b_filt;
    logic [cpst_pkg::POS_W-1:0]     r_b_pos;
    logic [cpst_pkg::POWER_W-1:0]   r_b_pow;
    logic signed [OFF_S_W-1:0]      r_b_off;

    // Result register
    logic                           r_out_valid;
    cpst_pkg::t_out_item            r_out;

    logic                           out_free;
    logic                           b_free;
    logic                           a_free;
    logic                           pop;

    logic signed [cpst_pkg::POS_W+1:0]  diff_sp;
    logic signed [26:0]                 prod;
    logic signed [26:0]                 base;
    logic signed [26:0]                 mix;
    logic [cpst_pkg::POS_W-1:0]         n_filt;

    logic signed [cpst_pkg::POS_W:0]    diff_t;
    logic signed [cpst_pkg::POS_W:0]    hyst_s;
    logic signed [OFF_S_W-1:0]          off_s;
    logic signed [OFF_S_W-1:0]          n_b_off;

    logic signed [OFF_S_W-1:0]          frame_s;
    logic signed [OFF_S_W-1:0]          wrapped;

    assign out_free    = ~r_out_valid | o_out.ready;
    assign b_free      = ~r_b_valid | out_free;
    assign a_free      = ~r_a_valid | b_free;
    assign o_rec_ready = a_free;
    assign pop         = i_rec_valid & a_free;

    // old*c + peak*(32767-c) is rewritten as peak*32767 + (old-peak)*c, so one
    // multiplier serves the filter.
    assign diff_sp = $signed({2'b00, r_smooth}) - $signed({2'b00, i_rec.peak_position});
    assign prod    = diff_sp * $signed({1'b0, i_cfg.smoothing_coef});
    assign base    = $signed({3'b000, i_rec.peak_position, 15'd0})
                   - $signed({18'd0, i_rec.peak_position});
    assign mix     = base + prod;
    assign n_filt  = i_rec.clear_filter ? i_rec.peak_position : mix[23:15];

    assign diff_t  = $signed({1'b0, r_a_filt}) - $signed({1'b0, i_cfg.target_position});
    assign hyst_s  = $signed({1'b0, i_cfg.hysteresis});
    assign off_s   = $signed({2'b00, r_a_off});
    always_comb begin
        if (diff_t > hyst_s) begin
            n_b_off = off_s + 21'sd1;
        end else if (diff_t < -hyst_s) begin
            n_b_off = off_s - 21'sd1;
        end else begin
            n_b_off = off_s;
        end
    end

    // A single wrap only: one add below zero or one subtract at or above the frame.
    assign frame_s = $signed({2'b00, i_cfg.frame_length});
    always_comb begin
        if (r_b_off < 0) begin
            wrapped = r_b_off + frame_s;
        end else if (r_b_off >= frame_s) begin
            wrapped = r_b_off - frame_s;
        end else begin
            wrapped = r_b_off;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth    <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_smooth <= n_filt;
            end
            if (a_free) begin
                r_a_valid <= i_rec_valid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (out_free) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_a_filt <= n_filt;
            r_a_pos  <= i_rec.peak_position;
            r_a_pow  <= i_rec.peak_power;
            r_a_off  <= i_rec.current_offset;
        end
        if (b_free && r_a_valid) begin
            r_b_filt <= r_a_filt;
            r_b_pos  <= r_a_pos;
            r_b_pow  <= r_a_pow;
            r_b_off  <= n_b_off;
        end
        if (out_free && r_b_valid) begin
            r_out.new_offset        <= wrapped[cpst_pkg::OFFSET_W-1:0];
            r_out.peak_position     <= r_b_pos;
            r_out.filtered_position <= r_b_filt;
            r_out.peak_power        <= r_b_pow;
        end
    end

    a_smooth_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pop |=> $stable(r_smooth))
        else $error("filter state changed without a record transfer");

    a_stage_a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_a_valid && r_a_filt == r_smooth)
        else $error("stage A does not hold the new filter state");

endmodule

@@ src/channel_peak_sync_tracker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_peak_sync_tracker_top
// OFDM timing tracker: per-position power sum over antennas, first strict
// peak per window, Q15 smoothing of the peak position and a hysteresis step
// of the receive offset with a single wrap at the frame length.
// ----------------------------------------------------------------------------
//  Port      Direction  Transfer moves
//  i_in      sink       one channel-estimate sample with window flags
//  o_out     source     one result at the end of each window
//  i_cfg_*   write      one configuration register (no wait, no read-back)
//
//  One sample is taken every cycle unless a window end meets a full queue; a
//  result passes stage 1, the queue, stages A, B and the result register.
//  The filter loop (one multiply and add) feeds its state register directly,
//  so one-sample windows also run at one per cycle while o_out is ready.
//  A two-entry record queue decouples the back end; the input stalls only when
//  the queue is full at a window end. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module channel_peak_sync_tracker_top #(
    parameter int MAX_WINDOW = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    cpst_in_if.sink                             i_in,
    cpst_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [cpst_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cpst_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    cpst_pkg::t_cfg     r_cfg;
    logic               rec_valid_f;
    logic               rec_ready_f;
    cpst_pkg::t_win_rec rec_f;
    logic               rec_valid_b;
    logic               rec_ready_b;
    cpst_pkg::t_win_rec rec_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smoothing_coef  <= cpst_pkg::COEF_RESET;
            r_cfg.target_position <= cpst_pkg::TARGET_RESET;
            r_cfg.hysteresis      <= cpst_pkg::HYST_RESET;
            r_cfg.frame_length    <= cpst_pkg::FRAME_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cpst_pkg::CFG_SMOOTHING_COEF: begin
                    r_cfg.smoothing_coef <= i_cfg_data[cpst_pkg::COEF_W-1:0];
                end
                cpst_pkg::CFG_TARGET_POSITION: begin
                    r_cfg.target_position <= i_cfg_data[cpst_pkg::POS_W-1:0];
                end
                cpst_pkg::CFG_HYSTERESIS: begin
                    r_cfg.hysteresis <= i_cfg_data[cpst_pkg::POS_W-1:0];
                end
                cpst_pkg::CFG_FRAME_LENGTH: begin
                    r_cfg.frame_length <= i_cfg_data[cpst_pkg::OFFSET_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    cpst_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_rec_valid (rec_valid_f),
        .i_rec_ready (rec_ready_f),
        .o_rec       (rec_f)
    );

    cpst_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (rec_valid_f),
        .o_push_ready (rec_ready_f),
        .i_push_rec   (rec_f),
        .o_pop_valid  (rec_valid_b),
        .i_pop_ready  (rec_ready_b),
        .o_pop_rec    (rec_b)
    );

    cpst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rec_valid (rec_valid_b),
        .o_rec_ready (rec_ready_b),
        .i_rec       (rec_b),
        .o_out       (o_out)
    );

endmodule

@@ sim/cpst_window_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpst_window_checker
// Watches the sample and result channels and the register write port of the
// channel peak sync tracker. It predicts each window result from the accepted
// samples and compares every result with the oldest prediction, field by
// field.
// ----------------------------------------------------------------------------
module cpst_window_checker #(
    parameter int MAX_WINDOW = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cpst_in_if                              i_samples,
    cpst_out_if                             i_results,
    input  logic                            i_cfg_we,
    input  logic [cpst_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cpst_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_pending
);

    localparam longint unsigned POWER_MAX   = 64'h1_FFFF_FFFF;
    localparam int              MAX_REPORTS = 10;

    logic [cpst_pkg::COEF_W-1:0]   cfg_coef;
    logic [cpst_pkg::POS_W-1:0]    cfg_target;
    logic [cpst_pkg::POS_W-1:0]    cfg_hyst;
    logic [cpst_pkg::OFFSET_W-1:0] cfg_frame;

    int                            position_count;
    logic [cpst_pkg::POWER_W-1:0]  power_accum;
    logic [cpst_pkg::POWER_W-1:0]  best_power;
    int                            best_position;
    logic [cpst_pkg::POS_W-1:0]    smoothed_position;

    cpst_pkg::t_out_item expected_windows[$];
    int                  mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic longint unsigned half_power(
        input logic signed [cpst_pkg::SAMPLE_W-1:0] v
    );
        longint mag;
        mag = v;
        if (mag < 0) mag = -mag;
        return (mag * mag) >> 1;
    endfunction

    // Folds one sample into the window state; returns 1 when it closes a window.
    function automatic bit track_sample(input cpst_pkg::t_in_item s,
                                        output cpst_pkg::t_out_item r);
        longint unsigned            acc;
        longint unsigned            filt;
        longint                     step_diff;
        longint                     offset;
        logic [cpst_pkg::POS_W-1:0] peak_pos;
        r = '0;
        acc = power_accum + half_power(s.sample_re) + half_power(s.sample_im);
        power_accum = cpst_pkg::POWER_W'((acc > POWER_MAX) ? POWER_MAX : acc);
        if (!s.last_antenna) return 1'b0;

        if (power_accum > best_power) begin
            best_power    = power_accum;
            best_position = position_count;
        end
        power_accum = '0;
        if (!s.last_position) begin
            if (position_count < MAX_WINDOW - 1) position_count++;
            return 1'b0;
        end

        peak_pos = cpst_pkg::POS_W'(best_position);
        if (s.clear_filter) begin
            filt = 64'(peak_pos);
        end else begin
            filt = (64'(smoothed_position) * 64'(cfg_coef)
                    + 64'(peak_pos) * (64'd32767 - 64'(cfg_coef))) >> 15;
        end
        smoothed_position = filt[cpst_pkg::POS_W-1:0];

        // Dead band around the target, then a single wrap at the frame length.
        step_diff = longint'(smoothed_position) - longint'(cfg_target);
        offset    = longint'(s.current_offset);
        if (step_diff > longint'(cfg_hyst)) offset++;
        else if (step_diff < -longint'(cfg_hyst)) offset--;
        if (offset < 0) offset += longint'(cfg_frame);
        else if (offset >= longint'(cfg_frame)) offset -= longint'(cfg_frame);

        r.new_offset        = offset[cpst_pkg::OFFSET_W-1:0];
        r.peak_position     = peak_pos;
        r.filtered_position = smoothed_position;
        r.peak_power        = best_power;

        position_count = 0;
        power_accum    = '0;
        best_power     = '0;
        best_position  = 0;
        return 1'b1;
    endfunction

    task automatic check_field(input string field, input longint unsigned want_v,
                               input longint unsigned got_v);
        if (want_v != got_v) begin
            if (mismatch_count < MAX_REPORTS) begin
                $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
            end
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        cpst_pkg::t_out_item predicted;
        cpst_pkg::t_out_item observed;
        if (!i_rst_n) begin
            cfg_coef          = cpst_pkg::COEF_RESET;
            cfg_target        = cpst_pkg::TARGET_RESET;
            cfg_hyst          = cpst_pkg::HYST_RESET;
            cfg_frame         = cpst_pkg::FRAME_RESET;
            position_count    = 0;
            power_accum       = '0;
            best_power        = '0;
            best_position     = 0;
            smoothed_position = '0;
            expected_windows.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cpst_pkg::CFG_SMOOTHING_COEF:
                        cfg_coef   = i_cfg_data[cpst_pkg::COEF_W-1:0];
                    cpst_pkg::CFG_TARGET_POSITION:
                        cfg_target = i_cfg_data[cpst_pkg::POS_W-1:0];
                    cpst_pkg::CFG_HYSTERESIS:
                        cfg_hyst   = i_cfg_data[cpst_pkg::POS_W-1:0];
                    cpst_pkg::CFG_FRAME_LENGTH:
                        cfg_frame  = i_cfg_data[cpst_pkg::OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (i_samples.valid && i_samples.ready) begin
                if (track_sample(i_samples.payload, predicted)) begin
                    expected_windows.push_back(predicted);
                end
            end
            if (i_results.valid && i_results.ready) begin
                observed = i_results.payload;
                if (expected_windows.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("%0t: result with no window pending: offset %0d peak %0d",
                                 $time, observed.new_offset, observed.peak_position);
                    end
                    mismatch_count++;
                end else begin
                    predicted = expected_windows.pop_front();
                    check_field("new_offset", predicted.new_offset, observed.new_offset);
                    check_field("peak_position", predicted.peak_position,
                                observed.peak_position);
                    check_field("filtered_position", predicted.filtered_position,
                                observed.filtered_position);
                    check_field("peak_power", predicted.peak_power, observed.peak_power);
                end
            end
        end
        o_pending <= expected_windows.size();
    end

endmodule

@@ sim/tb_channel_peak_sync_tracker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_channel_peak_sync_tracker_top
// Drives sample windows into the channel peak sync tracker under several
// register settings and idling patterns, with a long output stall to fill the
// block, and reports the verdict from the window checker.
// ----------------------------------------------------------------------------
module tb_channel_peak_sync_tracker_top;

    localparam int MAX_WINDOW   = 512;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 130;
    localparam int DRAIN_GAP    = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int FLOOD_ITEMS  = 40;
    localparam int PHASE_FLOOD  = 4;
    localparam int PHASE_LONG   = 3;
    localparam int LIMIT_NS     = 4_000_000;

    typedef enum int {WIN_CLEAN, WIN_SILENT, WIN_NOISY} t_win_style;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [cpst_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cpst_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              mismatches;
    int                              pending;

    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         cur_frame      = 76800;
    logic [7:0] hold_seq       = '0;
    logic [7:0] hold_seen      = '0;
    int         hold_left      = 0;

    // Register settings and idling per phase; phase 0 keeps the reset values.
    int ph_coef   [N_PHASES] = '{0, 32767, 16384, 0, 1000, 32000, 12345, 0};
    int ph_target [N_PHASES] = '{16, 0, 20, 511, 8, 16, 30, 16};
    int ph_hyst   [N_PHASES] = '{1, 0, 3, 511, 0, 2, 5, 1};
    int ph_frame  [N_PHASES] = '{76800, 1, 307200, 0, 524287, 100, 307199, 76800};
    int ph_sidle  [N_PHASES] = '{0, 77, 0, 14, 0, 77, 0, 14};
    int ph_rstall [N_PHASES] = '{0, 0, 77, 14, 0, 0, 77, 14};

    cpst_in_if  in_ch ();
    cpst_out_if out_ch ();

    channel_peak_sync_tracker_top #(
        .MAX_WINDOW (MAX_WINDOW)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cpst_window_checker #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_samples    (in_ch),
        .i_results    (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [cpst_pkg::SAMPLE_W-1:0] pick_sample(input t_win_style style);
        int small_val;
        small_val = int'($urandom_range(8)) - 4;
        if (style == WIN_SILENT) return '0;
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2, 3:    return 16'(small_val);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [cpst_pkg::OFFSET_W-1:0] pick_offset();
        case ($urandom_range(5))
            0:       return '0;
            1:       return cpst_pkg::OFFSET_W'(cur_frame - 1);
            2:       return cpst_pkg::OFFSET_W'(cur_frame);
            3:       return cpst_pkg::OFFSET_W'($urandom);
            default: return (cur_frame > 1)
                            ? cpst_pkg::OFFSET_W'($urandom_range(cur_frame - 1))
                            : cpst_pkg::OFFSET_W'($urandom);
        endcase
    endfunction

    function automatic cpst_pkg::t_in_item random_item(input t_win_style style,
                                                       input bit la, input bit lp);
        cpst_pkg::t_in_item s;
        s.sample_re      = pick_sample(style);
        s.sample_im      = pick_sample(style);
        s.last_antenna   = la;
        s.last_position  = lp;
        s.clear_filter   = ($urandom_range(3) == 0);
        s.current_offset = pick_offset();
        return s;
    endfunction

    function automatic cpst_pkg::t_in_item make_item(input int re, input int im,
                                                     input bit la, input bit lp,
                                                     input bit clr, input int off);
        cpst_pkg::t_in_item s;
        s.sample_re      = cpst_pkg::SAMPLE_W'(re);
        s.sample_im      = cpst_pkg::SAMPLE_W'(im);
        s.last_antenna   = la;
        s.last_position  = lp;
        s.clear_filter   = clr;
        s.current_offset = cpst_pkg::OFFSET_W'(off);
        return s;
    endfunction

    task automatic send_sample(input cpst_pkg::t_in_item s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= s;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Sends one search window; noisy windows carry stray window-end flags and
    // bursts of full-scale antennas that saturate the position sum.
    task automatic send_window(input int n_pos, input int max_ant, input t_win_style style,
                               output int n_sent);
        cpst_pkg::t_in_item s;
        int                 n_ant;
        bit                 burst;
        n_sent = 0;
        for (int p = 0; p < n_pos; p++) begin
            burst = (style == WIN_NOISY) && ($urandom_range(3) == 0);
            n_ant = burst ? $urandom_range(9, 12) : $urandom_range(1, max_ant);
            for (int a = 0; a < n_ant; a++) begin
                s = random_item(style, a == n_ant - 1, p == n_pos - 1);
                if (burst) begin
                    s.sample_re = 16'h8000;
                    s.sample_im = 16'h8000;
                end
                if (style == WIN_NOISY && !s.last_antenna) begin
                    s.last_position = 1'($urandom_range(1));
                end
                send_sample(s);
                n_sent++;
            end
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_settings(input int ph);
        cfg_we    <= 1'b1;
        cfg_index <= cpst_pkg::CFG_SMOOTHING_COEF;
        cfg_data  <= cpst_pkg::CFG_DATA_W'(ph_coef[ph]);
        @(posedge clk);
        cfg_index <= cpst_pkg::CFG_TARGET_POSITION;
        cfg_data  <= cpst_pkg::CFG_DATA_W'(ph_target[ph]);
        @(posedge clk);
        cfg_index <= cpst_pkg::CFG_HYSTERESIS;
        cfg_data  <= cpst_pkg::CFG_DATA_W'(ph_hyst[ph]);
        @(posedge clk);
        cfg_index <= cpst_pkg::CFG_FRAME_LENGTH;
        cfg_data  <= cpst_pkg::CFG_DATA_W'(ph_frame[ph]);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_frame = ph_frame[ph];
    endtask

    // The receiver holds off while one-sample windows keep arriving, so the
    // record queue fills and the sample channel has to stall.
    task automatic stall_output_and_flood();
        hold_seq <= hold_seq + 1'b1;
        for (int i = 0; i < FLOOD_ITEMS; i++) begin
            send_sample(random_item(WIN_CLEAN, 1'b1, 1'b1));
        end
        wait_drained();
    endtask

    task automatic run_directed();
        // Lone sample with both extremes, clear and a wrap below zero.
        send_sample(make_item(32767, -32768, 1, 1, 1, 0));
        // Silent window: every power is zero.
        send_sample(make_item(0, 0, 1, 0, 0, 0));
        send_sample(make_item(-1, 1, 1, 1, 0, 76799));
        // Window-end flag without the last antenna is ignored; offset above range.
        send_sample(make_item(100, 0, 0, 1, 0, 0));
        send_sample(make_item(0, 100, 1, 1, 0, 524287));
        // Equal powers: the first position wins.
        send_sample(make_item(10, 0, 1, 0, 0, 0));
        send_sample(make_item(0, 10, 1, 1, 1, 76800));
        // Ten full-scale antennas saturate the position sum.
        for (int a = 0; a < 9; a++) send_sample(make_item(-32768, -32768, 0, 0, 0, 0));
        send_sample(make_item(-32768, -32768, 1, 0, 0, 0));
        send_sample(make_item(32767, 32767, 1, 1, 0, 12345));
        // Strictly rising powers put the peak on the last position.
        send_sample(make_item(1, 1, 1, 0, 0, 0));
        send_sample(make_item(2, 2, 1, 0, 0, 0));
        send_sample(make_item(300, -300, 1, 1, 0, 0));
        wait_drained();
    endtask

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int         budget;
        int         n_sent;
        int         n_pos;
        int         pick;
        t_win_style style;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= cpst_pkg::CFG_SMOOTHING_COEF;
        cfg_data      <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int ph = 1; ph < N_PHASES; ph++) begin
            write_settings(ph);
            send_idle_pct  = ph_sidle[ph];
            recv_stall_pct = ph_rstall[ph];
            if (ph == PHASE_LONG) begin
                // Longer than the position counter can follow.
                send_window(MAX_WINDOW + 3 + $urandom_range(10), 1, WIN_CLEAN, n_sent);
            end
            if (ph == PHASE_FLOOD) stall_output_and_flood();
            budget = 0;
            while (budget < PHASE_ITEMS) begin
                pick  = $urandom_range(99);
                style = (pick < 75) ? WIN_CLEAN : (pick < 80) ? WIN_SILENT : WIN_NOISY;
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: n_pos = $urandom_range(1, 4);
                    5, 6, 7:       n_pos = $urandom_range(5, 24);
                    default:       n_pos = $urandom_range(25, 48);
                endcase
                send_window(n_pos, $urandom_range(1, 4), style, n_sent);
                budget += n_sent;
            end
            wait_drained();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule
